[src/ubd_pkg.sv]
// Shared types, codes and helpers of the UART boot download engine.
package ubd_pkg;

    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    localparam logic [7:0] BYTE_HELLO = 8'h81;
    localparam logic [7:0] BYTE_OK    = 8'h4F; // 'O'
    localparam logic [7:0] CMD_BAUD   = 8'h52; // 'R'
    localparam logic [7:0] CMD_ADDR   = 8'h53; // 'S'
    localparam logic [7:0] CMD_LOAD   = 8'h4C; // 'L'
    localparam logic [7:0] CMD_JUMP   = 8'h4A; // 'J'

    localparam logic [31:0] CONNECT_TIMEOUT_RST = 32'd20000000;
    localparam logic [31:0] FIELD_TIMEOUT_RST   = 32'd1000000;
    localparam logic [31:0] DATA_TIMEOUT_RST    = 32'd2000000;
    localparam logic [31:0] REMAP_LIMIT_RST     = 32'd65536;
    localparam logic [31:0] REMAP_BASE_RST      = 32'd0;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_ERROR = 2'd2,
        OP_TICK  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_CONNECT_TIMEOUT = 3'd0,
        CFG_FIELD_TIMEOUT   = 3'd1,
        CFG_DATA_TIMEOUT    = 3'd2,
        CFG_REMAP_LIMIT     = 3'd3,
        CFG_REMAP_BASE      = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CONNECT = 3'd1,
        PH_CMD     = 3'd2,
        PH_BAUD    = 3'd3,
        PH_ADDR    = 3'd4,
        PH_SIZE    = 3'd5,
        PH_DATA    = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_SEND  = 3'd0,
        KIND_WRITE = 3'd1,
        KIND_BAUD  = 3'd2,
        KIND_JUMP  = 3'd3,
        KIND_DONE  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_JUMPED  = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_RXERR   = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_REFUSED = 3'd4
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic [31:0] address;
        logic [31:0] value;
        status_t     status;
        logic        last;
    } res_t;

    // one or two results caused by one input transaction
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } job_t;

    function automatic res_t mk_res(kind_t k, logic [7:0] tx, logic [31:0] addr,
                                    logic [31:0] val, status_t st, logic lst);
        res_t r;
        r.kind    = k;
        r.tx_byte = tx;
        r.address = addr;
        r.value   = val;
        r.status  = st;
        r.last    = lst;
        return r;
    endfunction

endpackage

[src/uart_boot_download_protocol.sv]
// Top level of the UART boot download protocol engine.
//
//  channel   handshake               payload
//  --------  ----------------------  ---------------------------------------------
//  input     push / full             opcode, rx_byte
//  result    empty / pop             kind, tx_byte, address, value, status, last
//  config    cfg_we (no back-press)  cfg_index, cfg_data
//
// Flow: the front end consumes one input transaction per cycle while full is low
// and updates the session state in that cycle; the sequencer puts out one result
// per cycle while the output register is free or popped, through a single output
// register, so an item with two results leaves it as two results, r0 then r1.
// Reset: asynchronous, active low; config registers return to their defaults,
// the session goes idle and the job queue and output register empty.
// Stalls: a two-entry job queue lets input keep flowing while pop is held low;
// full rises only when both queue entries are taken.
module uart_boot_download_protocol (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [7:0]  rx_byte,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [7:0]  tx_byte,
    output logic [31:0] address,
    output logic [31:0] value,
    output logic [2:0]  status,
    output logic        last,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic          accept;
    logic          job_push;
    ubd_pkg::job_t job_in, job_head;
    logic          q_empty, q_pop;
    logic          out_valid;
    ubd_pkg::res_t out_res;

    // items that cause no result still need a free slot, which keeps this simple
    assign accept = push && !full;

    ubd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .opcode    (opcode),
        .rx_byte   (rx_byte),
        .job_push  (job_push),
        .job       (job_in)
    );

    // push only on an accepted transaction that produced results
    ubd_job_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept && job_push),
        .wdata (job_in),
        .full  (full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (job_head)
    );

    ubd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (job_head),
        .q_pop     (q_pop),
        .pop       (pop),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign empty   = !out_valid;
    assign kind    = out_res.kind;
    assign tx_byte = out_res.tx_byte;
    assign address = out_res.address;
    assign value   = out_res.value;
    assign status  = out_res.status;
    assign last    = out_res.last;

endmodule

[src/ubd_front.sv]
// Protocol front end: config registers, session state, result job build.
module ubd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                accept,
    input  logic [1:0]          opcode,
    input  logic [7:0]          rx_byte,
    output logic                job_push,
    output ubd_pkg::job_t       job
);

    logic [31:0] conn_to_reg, field_to_reg, data_to_reg, remap_limit_reg, remap_base_reg;

    ubd_pkg::phase_t phase_reg, phase_next;
    logic [31:0] shift_reg, shift_next;
    logic [1:0]  count_reg, count_next;
    logic [31:0] load_addr_reg, load_addr_next;
    logic [10:0] left_reg, left_next;
    logic [31:0] wait_reg, wait_next;

    logic [31:0] lim_raw, lim, wait_inc, shift_new, remapped;
    logic [10:0] left_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_to_reg     <= ubd_pkg::CONNECT_TIMEOUT_RST;
            field_to_reg    <= ubd_pkg::FIELD_TIMEOUT_RST;
            data_to_reg     <= ubd_pkg::DATA_TIMEOUT_RST;
            remap_limit_reg <= ubd_pkg::REMAP_LIMIT_RST;
            remap_base_reg  <= ubd_pkg::REMAP_BASE_RST;
        end
        else if (cfg_we)
        begin
            case (ubd_pkg::cfg_index_t'(cfg_index))
                ubd_pkg::CFG_CONNECT_TIMEOUT: conn_to_reg     <= cfg_data;
                ubd_pkg::CFG_FIELD_TIMEOUT:   field_to_reg    <= cfg_data;
                ubd_pkg::CFG_DATA_TIMEOUT:    data_to_reg     <= cfg_data;
                ubd_pkg::CFG_REMAP_LIMIT:     remap_limit_reg <= cfg_data;
                ubd_pkg::CFG_REMAP_BASE:      remap_base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ubd_pkg::PH_IDLE;
            shift_reg     <= '0;
            count_reg     <= '0;
            load_addr_reg <= '0;
            left_reg      <= '0;
            wait_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            load_addr_reg <= load_addr_next;
            left_reg      <= left_next;
            wait_reg      <= wait_next;
        end
    end

    // timeout of zero behaves as one
    always_comb
    begin
        case (phase_reg)
            ubd_pkg::PH_CONNECT: lim_raw = conn_to_reg;
            ubd_pkg::PH_DATA:    lim_raw = data_to_reg;
            default:             lim_raw = field_to_reg;
        endcase
        lim       = (lim_raw == 32'd0) ? 32'd1 : lim_raw;
        wait_inc  = wait_reg + 32'd1;
        shift_new = shift_reg;
        case (count_reg)
            2'd0:    shift_new[7:0]   = shift_reg[7:0]   | rx_byte;
            2'd1:    shift_new[15:8]  = shift_reg[15:8]  | rx_byte;
            2'd2:    shift_new[23:16] = shift_reg[23:16] | rx_byte;
            default: shift_new[31:24] = shift_reg[31:24] | rx_byte;
        endcase
        remapped = (shift_new < remap_limit_reg) ? shift_new + remap_base_reg : shift_new;
        left_dec = (left_reg != 11'd0) ? left_reg - 11'd1 : left_reg;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        count_next     = count_reg;
        load_addr_next = load_addr_reg;
        left_next      = left_reg;
        wait_next      = wait_reg;
        job_push       = 1'b0;
        job            = '0;

        case (ubd_pkg::opcode_t'(opcode))
            ubd_pkg::OP_START:
            begin
                phase_next     = ubd_pkg::PH_CONNECT;
                shift_next     = '0;
                count_next     = '0;
                load_addr_next = '0;
                left_next      = '0;
                wait_next      = '0;
                job_push       = 1'b1;
                job.r0 = ubd_pkg::mk_res(ubd_pkg::KIND_SEND, ubd_pkg::BYTE_HELLO, '0, '0,
                                         ubd_pkg::ST_JUMPED, 1'b1);
            end
            ubd_pkg::OP_ERROR:
            begin
                if (phase_reg != ubd_pkg::PH_IDLE)
                begin
                    phase_next = ubd_pkg::PH_IDLE;
                    job_push   = 1'b1;
                    job.r0 = ubd_pkg::mk_res(ubd_pkg::KIND_DONE, '0, '0, '0,
                                             ubd_pkg::ST_RXERR, 1'b1);
                end
            end
            ubd_pkg::OP_TICK:
            begin
                if (phase_reg != ubd_pkg::PH_IDLE && phase_reg != ubd_pkg::PH_CMD)
                begin
                    wait_next = wait_inc;
                    if (wait_inc >= lim)
                    begin
                        phase_next = ubd_pkg::PH_IDLE;
                        job_push   = 1'b1;
                        job.r0 = ubd_pkg::mk_res(ubd_pkg::KIND_DONE, '0, '0, '0,
                                                 ubd_pkg::ST_TIMEOUT, 1'b1);
                    end
                end
            end
            default: // received byte
            begin
                case (phase_reg)
                    ubd_pkg::PH_CONNECT:
                    begin
                        if (rx_byte == ubd_pkg::BYTE_OK)
                        begin
                            phase_next = ubd_pkg::PH_CMD;
                        end
                        else
                        begin
                            phase_next = ubd_pkg::PH_IDLE;
                            job_push   = 1'b1;
                            job.r0 = ubd_pkg::mk_res(ubd_pkg::KIND_DONE, '0, '0, '0,
                                                     ubd_pkg::ST_REFUSED, 1'b1);
                        end
                    end
                    ubd_pkg::PH_CMD:
                    begin
                        shift_next = '0;
                        count_next = '0;
                        wait_next  = '0;
                        if (rx_byte == ubd_pkg::CMD_BAUD)
                        begin
                            phase_next = ubd_pkg::PH_BAUD;
                        end
                        else if (rx_byte == ubd_pkg::CMD_ADDR)
                        begin
                            phase_next = ubd_pkg::PH_ADDR;
                        end
                        else if (rx_byte == ubd_pkg::CMD_LOAD)
                        begin
                            phase_next = ubd_pkg::PH_SIZE;
                        end
                        else
                        begin
                            // leave field state as it was
                            shift_next = shift_reg;
                            count_next = count_reg;
                            wait_next  = wait_reg;
                            phase_next = ubd_pkg::PH_IDLE;
                            job_push   = 1'b1;
                            if (rx_byte == ubd_pkg::CMD_JUMP)
                            begin
                                job.two = 1'b1;
                                job.r0 = ubd_pkg::mk_res(ubd_pkg::KIND_JUMP, '0,
                                                         load_addr_reg, '0,
                                                         ubd_pkg::ST_JUMPED, 1'b0);
                                job.r1 = ubd_pkg::mk_res(ubd_pkg::KIND_DONE, '0, '0, '0,
                                                         ubd_pkg::ST_JUMPED, 1'b1);
                            end
                            else
                            begin
                                job.r0 = ubd_pkg::mk_res(ubd_pkg::KIND_DONE, '0, '0, '0,
                                                         ubd_pkg::ST_UNKNOWN, 1'b1);
                            end
                        end
                    end
                    ubd_pkg::PH_BAUD, ubd_pkg::PH_ADDR:
                    begin
                        shift_next = shift_new;
                        if (count_reg != 2'd3)
                        begin
                            count_next = count_reg + 2'd1;
                        end
                        else
                        begin
                            count_next = '0;
                            phase_next = ubd_pkg::PH_CMD;
                            job_push   = 1'b1;
                            if (phase_reg == ubd_pkg::PH_BAUD)
                            begin
                                job.two = 1'b1;
                                job.r0 = ubd_pkg::mk_res(ubd_pkg::KIND_BAUD, '0, '0,
                                                         shift_new, ubd_pkg::ST_JUMPED,
                                                         1'b0);
                                job.r1 = ubd_pkg::mk_res(ubd_pkg::KIND_SEND,
                                                         ubd_pkg::BYTE_OK, '0, '0,
                                                         ubd_pkg::ST_JUMPED, 1'b1);
                            end
                            else
                            begin
                                load_addr_next = remapped;
                                job.r0 = ubd_pkg::mk_res(ubd_pkg::KIND_SEND,
                                                         ubd_pkg::BYTE_OK, '0, '0,
                                                         ubd_pkg::ST_JUMPED, 1'b1);
                            end
                        end
                    end
                    ubd_pkg::PH_SIZE:
                    begin
                        left_next  = {1'b0, rx_byte, 2'b00} + 11'd4;
                        phase_next = ubd_pkg::PH_DATA;
                        wait_next  = '0;
                    end
                    ubd_pkg::PH_DATA:
                    begin
                        load_addr_next = load_addr_reg + 32'd1;
                        left_next      = left_dec;
                        job_push       = 1'b1;
                        job.r0 = ubd_pkg::mk_res(ubd_pkg::KIND_WRITE, '0, load_addr_reg,
                                                 {24'd0, rx_byte}, ubd_pkg::ST_JUMPED,
                                                 (left_dec != 11'd0));
                        if (left_dec == 11'd0)
                        begin
                            phase_next = ubd_pkg::PH_CMD;
                            job.two    = 1'b1;
                            job.r1 = ubd_pkg::mk_res(ubd_pkg::KIND_SEND, ubd_pkg::BYTE_OK,
                                                     '0, '0, ubd_pkg::ST_JUMPED, 1'b1);
                        end
                    end
                    default: ; // idle: byte ignored
                endcase
            end
        endcase
    end

endmodule

[src/ubd_job_fifo.sv]
// Short job queue between the protocol front end and the result sequencer.
module ubd_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ubd_pkg::job_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output ubd_pkg::job_t rdata
);

    ubd_pkg::job_t                  mem_reg [ubd_pkg::JOB_DEPTH];
    logic [ubd_pkg::JOB_PTR_W-1:0]  wr_reg, rd_reg;
    logic [ubd_pkg::JOB_CNT_W-1:0]  cnt_reg;
    logic                           do_push, do_pop;

    assign full    = (cnt_reg == ubd_pkg::JOB_CNT_W'(ubd_pkg::JOB_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == ubd_pkg::JOB_PTR_W'(ubd_pkg::JOB_DEPTH - 1))
                          ? '0 : wr_reg + ubd_pkg::JOB_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == ubd_pkg::JOB_PTR_W'(ubd_pkg::JOB_DEPTH - 1))
                          ? '0 : rd_reg + ubd_pkg::JOB_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + ubd_pkg::JOB_CNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - ubd_pkg::JOB_CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

[src/ubd_back.sv]
// Result sequencer: splits each job into results and holds the output register.
module ubd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  ubd_pkg::job_t q_head,
    output logic          q_pop,
    input  logic          pop,
    output logic          out_valid,
    output ubd_pkg::res_t out_res
);

    logic          out_valid_reg, out_valid_next;
    ubd_pkg::res_t out_res_reg, out_res_next;
    logic          sel_reg, sel_next;
    logic          take;

    always_comb
    begin
        take           = (!out_valid_reg || pop) && !q_empty;
        q_pop          = take && (sel_reg || !q_head.two);
        out_valid_next = out_valid_reg && !pop;
        out_res_next   = out_res_reg;
        sel_next       = sel_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = sel_reg ? q_head.r1 : q_head.r0;
            sel_next       = !q_pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

[src/ubd_checker.sv]
// Port-level checks on the result stream of the boot download engine.
module ubd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  kind,
    input logic [7:0]  tx_byte,
    input logic [31:0] value,
    input logic [2:0]  status,
    input logic        last
);

    // a held result must not change while waiting
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(value) && $stable(last)))
        else $error("result changed while stalled");

    // a jump is never marked last; the session-finished result follows it in its group
    a_jump_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == ubd_pkg::KIND_JUMP) |-> !last)
        else $error("jump marked last");

    // session end and byte sends always close their group
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == ubd_pkg::KIND_DONE || kind == ubd_pkg::KIND_SEND)) |-> last)
        else $error("done/send not last");

    // memory writes carry one byte and no status
    a_write_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == ubd_pkg::KIND_WRITE)
            |-> (value[31:8] == 24'd0 && tx_byte == 8'd0 && status == 3'd0))
        else $error("bad memory write fields");

endmodule

bind uart_boot_download_protocol ubd_checker u_ubd_checker (.*);
